@@ sv/pidrr_pkg.sv @@
// Package with the shared types and constants of the roll-rate PID steering duty unit.
`timescale 1ns / 1ps

package pidrr_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GAIN_W           = 16;
  localparam int INTEG_W          = 16;
  localparam int LIMIT_W          = 15;
  localparam int DUTY_W           = 15;
  localparam int APB_ADDR_W       = 4;
  localparam int APB_DATA_W       = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd24576;

  // 33.3 / pi in Q16, applied one constant bit per cycle.
  localparam int                CONV_W   = 20;
  localparam logic [CONV_W-1:0] CONV_Q16 = 20'd694663;

  localparam int FRAC_SHIFT = 28;
  localparam int DUTY_FULL  = 25600;
  // Mid duty of 50 percent in Q36 plus one half LSB of Q7.8 for rounding.
  localparam logic [63:0] DUTY_BASE_Q36 = 64'd25601 << 27;

  typedef enum logic [1:0] {
    REG_GAIN_P  = 2'd0,
    REG_GAIN_I  = 2'd1,
    REG_GAIN_D  = 2'd2,
    REG_LIMIT   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CONV,
    ST_FIN
  } state_e;

endpackage

@@ sv/pid_roll_rate_to_steering_duty_unit.sv @@
// Roll-rate PID controller with integral clamp and bit-serial steering duty computation.
// Inputs are taken only in the idle state: the shared bit-serial shift-add unit forms the three
// gain products in turn and then the duty scale before a new item can be accepted.
// A finished result waits in the output register while the next item is accepted; the unit
// stalls before writing the next result until that register has been taken.
// Reset clears the gains, integral and last error and sets the integral limit to 6.0.
`timescale 1ns / 1ps

module pid_roll_rate_to_steering_duty_unit
  import pidrr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] roll_rate_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DUTY_W-1:0]       steer_duty_o,
  output logic                    duty_saturated_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int IW   = ((SW + 1 > INTEG_W) ? SW + 1 : INTEG_W) + 1;
  localparam int DW   = SW + 24;
  localparam int PW   = DW + 22;
  localparam int HW   = PW - FRAC_SHIFT;
  localparam int GB_W = $clog2(GAIN_W);
  localparam int CB_W = $clog2(CONV_W);

  localparam logic [PW-1:0] W_INIT = PW'(DUTY_BASE_Q36);

  logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic        [LIMIT_W-1:0] limit_q;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [SW:0]        last_err_q;
  logic signed [SW+1:0]      deriv_q, deriv_d;

  state_e            state_q, state_d;
  logic [GB_W-1:0]   gbit_q, gbit_d;
  logic [1:0]        term_q, term_d;
  logic [CB_W-1:0]   cbit_q, cbit_d;
  logic [PW-1:0]     opnd_q, opnd_d;
  logic [PW-1:0]     acc_q, acc_d;
  logic [GAIN_W-1:0] gain_q, gain_d;

  logic              out_valid_q, out_valid_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic              sat_q, sat_d;

  logic              in_fire, cfg_write;
  logic signed [SW:0]     err;
  logic signed [IW-1:0]   integ_raw, lim_pos, lim_neg;
  logic [HW-1:0]          duty_hi;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_GAIN_P: prdata = {{(APB_DATA_W-GAIN_W){gain_p_q[GAIN_W-1]}}, gain_p_q};
      REG_GAIN_I: prdata = {{(APB_DATA_W-GAIN_W){gain_i_q[GAIN_W-1]}}, gain_i_q};
      REG_GAIN_D: prdata = {{(APB_DATA_W-GAIN_W){gain_d_q[GAIN_W-1]}}, gain_d_q};
      REG_LIMIT:  prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, limit_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      limit_q  <= LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
        REG_LIMIT:  limit_q  <= pwdata[LIMIT_W-1:0];
        default:    limit_q  <= limit_q;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  assign err       = -$signed({roll_rate_i[SW-1], roll_rate_i});
  assign integ_raw = $signed({{(IW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q})
                   + $signed({{(IW-SW-1){err[SW]}}, err});
  assign lim_pos   = $signed({{(IW-LIMIT_W){1'b0}}, limit_q});
  assign lim_neg   = -lim_pos;
  assign deriv_d   = $signed({err[SW], err}) - $signed({last_err_q[SW], last_err_q});

  always_comb begin
    if (integ_raw < lim_neg) begin
      integ_d = lim_neg[INTEG_W-1:0];
    end else if (integ_raw > lim_pos) begin
      integ_d = lim_pos[INTEG_W-1:0];
    end else begin
      integ_d = integ_raw[INTEG_W-1:0];
    end
  end

  assign duty_hi = acc_q[PW-1:FRAC_SHIFT];

  always_comb begin
    logic [PW-1:0] partial;
    state_d     = state_q;
    gbit_d      = gbit_q;
    term_d      = term_q;
    cbit_d      = cbit_q;
    opnd_d      = opnd_q;
    acc_d       = acc_q;
    gain_d      = gain_q;
    out_valid_d = out_valid_q;
    duty_d      = duty_q;
    sat_d       = sat_q;
    partial     = gain_q[0] ? opnd_q : '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          opnd_d  = {{(PW-SW-1){err[SW]}}, err};
          gain_d  = gain_p_q;
          acc_d   = '0;
          gbit_d  = '0;
          term_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (gbit_q == GB_W'(GAIN_W - 1)) begin
          acc_d = acc_q - partial;
        end else begin
          acc_d = acc_q + partial;
        end
        opnd_d = opnd_q << 1;
        gain_d = gain_q >> 1;
        gbit_d = gbit_q + GB_W'(1);
        if (gbit_q == GB_W'(GAIN_W - 1)) begin
          term_d = term_q + 2'd1;
          if (term_q == 2'd0) begin
            opnd_d = {{(PW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
            gain_d = gain_i_q;
          end else if (term_q == 2'd1) begin
            opnd_d = {{(PW-SW-2){deriv_q[SW+1]}}, deriv_q};
            gain_d = gain_d_q;
          end else begin
            opnd_d  = acc_d;
            acc_d   = W_INIT;
            cbit_d  = '0;
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (CONV_Q16[cbit_q]) begin
          acc_d = acc_q - opnd_q;
        end
        opnd_d = opnd_q << 1;
        cbit_d = cbit_q + CB_W'(1);
        if (cbit_q == CB_W'(CONV_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (acc_q[PW-1]) begin
            duty_d = '0;
            sat_d  = 1'b1;
          end else if (duty_hi > HW'(DUTY_FULL)) begin
            duty_d = DUTY_W'(DUTY_FULL);
            sat_d  = 1'b1;
          end else begin
            duty_d = duty_hi[DUTY_W-1:0];
            sat_d  = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gbit_q      <= '0;
      term_q      <= '0;
      cbit_q      <= '0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= '0;
    end else begin
      state_q     <= state_d;
      gbit_q      <= gbit_d;
      term_q      <= term_d;
      cbit_q      <= cbit_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        integ_q    <= integ_d;
        last_err_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    acc_q  <= acc_d;
    gain_q <= gain_d;
    duty_q <= duty_d;
    sat_q  <= sat_d;
    if (in_fire) begin
      deriv_q <= deriv_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign steer_duty_o     = duty_q;
  assign duty_saturated_o = sat_q;

endmodule

@@ tb/pid_roll_rate_to_steering_duty_unit_test.sv @@
// Self-checking testbench for the roll-rate PID steering duty unit, with its own duty predictor.
`timescale 1ns / 1ps

module pid_roll_rate_to_steering_duty_unit_test;
  import pidrr_pkg::*;

  localparam longint DUTY_MID_Q36  = longint'(12800) * (longint'(1) <<< 28);
  localparam longint DUTY_HALF_Q36 = longint'(1) <<< 27;
  localparam longint DUTY_CONV_Q16 = 694663;
  localparam longint DUTY_MAX_Q8   = 25600;
  localparam int     TAIL_CYCLES   = 80;
  localparam int     RANDOM_PHASES = 25;
  localparam int     PHASE_ITEMS   = 50;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              sat;
  } duty_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [15:0]           roll_rate_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [DUTY_W-1:0]     steer_duty_o;
  logic                  duty_saturated_o;

  // Register copies and loop state of the predictor.
  logic signed [15:0]    gain_p_m = '0;
  logic signed [15:0]    gain_i_m = '0;
  logic signed [15:0]    gain_d_m = '0;
  logic [LIMIT_W-1:0]    limit_m = LIMIT_RESET;
  longint                integ_m = 0;
  longint                err_prev_m = 0;

  duty_result_t          duty_expected_q[$];
  duty_result_t          duty_want;
  int                    error_count = 0;
  int                    ready_stall = 0;
  bit                    quiet = 1'b0;

  pid_roll_rate_to_steering_duty_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .roll_rate_i     (roll_rate_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .steer_duty_o    (steer_duty_o),
    .duty_saturated_o(duty_saturated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic predict_duty(input logic [15:0] sample);
    longint       err;
    longint       integ;
    longint       deriv;
    longint       drive;
    longint       w;
    duty_result_t r;
    err = -longint'($signed(sample));
    integ = integ_m + err;
    if (integ < -longint'(limit_m)) integ = -longint'(limit_m);
    else if (integ > longint'(limit_m)) integ = longint'(limit_m);
    deriv = err - err_prev_m;
    integ_m = integ;
    err_prev_m = err;
    drive = longint'(gain_p_m) * err + longint'(gain_i_m) * integ + longint'(gain_d_m) * deriv;
    w = DUTY_MID_Q36 - drive * DUTY_CONV_Q16 + DUTY_HALF_Q36;
    if (w < 0) begin
      r.duty = '0;
      r.sat = 1'b1;
    end else if ((w >>> 28) > DUTY_MAX_Q8) begin
      r.duty = DUTY_W'(DUTY_MAX_Q8);
      r.sat = 1'b1;
    end else begin
      r.duty = DUTY_W'(w >>> 28);
      r.sat = 1'b0;
    end
    duty_expected_q.push_back(r);
  endtask

  task automatic send_sample(input logic [15:0] sample);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    roll_rate_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    predict_duty(sample);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (duty_expected_q.size() != 0);
  endtask

  task automatic apb_xfer(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e idx);
    logic [31:0] rd;
    logic        ok;
    apb_xfer(1'b0, idx, '0, rd);
    case (idx)
      REG_GAIN_P: ok = (rd[15:0] == gain_p_m);
      REG_GAIN_I: ok = (rd[15:0] == gain_i_m);
      REG_GAIN_D: ok = (rd[15:0] == gain_d_m);
      default:    ok = (rd[LIMIT_W-1:0] == limit_m);
    endcase
    if (!ok) report_mismatch($sformatf("register %s read back 0x%08h", idx.name(), rd));
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] data);
    logic [31:0] unused_rd;
    apb_xfer(1'b1, idx, data, unused_rd);
    case (idx)
      REG_GAIN_P: gain_p_m = data[15:0];
      REG_GAIN_I: gain_i_m = data[15:0];
      REG_GAIN_D: gain_d_m = data[15:0];
      default:    limit_m = data[LIMIT_W-1:0];
    endcase
    check_reg(idx);
  endtask

  task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki, input logic [15:0] kd);
    cfg_write(REG_GAIN_P, {16'($urandom_range(0, 65535)), kp});
    cfg_write(REG_GAIN_I, {16'($urandom_range(0, 65535)), ki});
    cfg_write(REG_GAIN_D, {16'($urandom_range(0, 65535)), kd});
  endtask

  function automatic logic [31:0] rand_gain_word();
    logic [31:0] w;
    int          r;
    w = $urandom();
    r = $urandom_range(0, 9);
    case (r)
      0: w[15:0] = 16'h8000;
      1: w[15:0] = 16'h7fff;
      2: w[15:0] = 16'h0000;
      3, 4: ;
      default: w[15:0] = 16'($urandom_range(0, 600)) - 16'd300;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_limit_word();
    logic [31:0] w;
    int          r;
    w = $urandom();
    r = $urandom_range(0, 9);
    if (r == 0) w[LIMIT_W-1:0] = '0;
    else if (r == 1) w[LIMIT_W-1:0] = '1;
    else if (r > 3) w[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 8192));
    return w;
  endfunction

  function automatic logic [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r == 2) return 16'h0000;
    if (r < 10) return 16'($urandom());
    return 16'($urandom_range(0, 3000)) - 16'd1500;
  endfunction

  task automatic test_reset_values();
    check_reg(REG_GAIN_P);
    check_reg(REG_GAIN_I);
    check_reg(REG_GAIN_D);
    check_reg(REG_LIMIT);
    send_sample(16'h0000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    wait_all_results();
  endtask

  task automatic test_proportional_extremes();
    set_gains(16'h7fff, 16'h0000, 16'h0000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    wait_all_results();
    set_gains(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    wait_all_results();
  endtask

  // The second and fourth samples drive the duty to exactly 0 and full scale without clipping.
  task automatic test_exact_duty_bounds();
    set_gains(16'd151, 16'h0000, 16'd1);
    send_sample(-16'sd32689);
    send_sample(-16'sd32756);
    send_sample(16'sd32689);
    send_sample(16'sd32756);
    wait_all_results();
  endtask

  task automatic test_integral_clamp();
    set_gains(16'h0000, 16'd256, 16'h0000);
    cfg_write(REG_LIMIT, 32'hffff_ffff);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h8000);
    wait_all_results();
    cfg_write(REG_LIMIT, 32'h0000_0064);
    send_sample(16'h0000);
    wait_all_results();
    cfg_write(REG_GAIN_I, 32'h0000_8000);
    cfg_write(REG_LIMIT, 32'h0000_8000);
    send_sample(16'h7fff);
    wait_all_results();
  endtask

  task automatic test_derivative_swing();
    set_gains(16'h0000, 16'h0000, 16'h7fff);
    cfg_write(REG_LIMIT, {17'h0, LIMIT_RESET});
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiet = (ph % 5 == 2);
      cfg_write(REG_GAIN_P, rand_gain_word());
      cfg_write(REG_GAIN_I, rand_gain_word());
      cfg_write(REG_GAIN_D, rand_gain_word());
      cfg_write(REG_LIMIT, rand_limit_word());
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(rand_sample());
      wait_all_results();
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (ready_stall != 0) begin
      out_ready_i <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      ready_stall <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (duty_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer duty=%0d sat=%0b",
                                  steer_duty_o, duty_saturated_o));
      end else begin
        duty_want = duty_expected_q.pop_front();
        if (steer_duty_o !== duty_want.duty)
          report_mismatch($sformatf("steer_duty got %0d want %0d", steer_duty_o, duty_want.duty));
        if (duty_saturated_o !== duty_want.sat)
          report_mismatch($sformatf("duty_saturated got %0b want %0b",
                                    duty_saturated_o, duty_want.sat));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_proportional_extremes();
    test_exact_duty_bounds();
    test_integral_clamp();
    test_derivative_swing();
    test_random_traffic();
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TIMEOUT at %0t ns", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pidrr_pkg.sv
sv/pid_roll_rate_to_steering_duty_unit.sv
tb/pid_roll_rate_to_steering_duty_unit_test.sv
